FILE: design/nrte_pkg.sv
// Package for the NMEA RMC time extractor: parser phase codes, character
// codes and the hex digit and hour conversion functions.
// Used by nmea_rmc_time_extractor_core; depends on nothing.
`default_nettype none

package nrte_pkg;

    localparam int PHASE_W = 4;
    localparam int COUNT_W = 5;
    localparam int NIB_W   = 4;
    localparam int BYTE_W  = 8;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 4'd0;
    localparam logic [PHASE_W-1:0] PH_HDR_G = 4'd1;
    localparam logic [PHASE_W-1:0] PH_HDR_P = 4'd2;
    localparam logic [PHASE_W-1:0] PH_HDR_R = 4'd3;
    localparam logic [PHASE_W-1:0] PH_HDR_M = 4'd4;
    localparam logic [PHASE_W-1:0] PH_HDR_C = 4'd5;
    localparam logic [PHASE_W-1:0] PH_COMMA = 4'd6;
    localparam logic [PHASE_W-1:0] PH_TIME  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_STAR  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_SUM_H = 4'd9;
    localparam logic [PHASE_W-1:0] PH_SUM_L = 4'd10;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
    localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
    localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_C      = 8'h43;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;

    localparam logic [BYTE_W-1:0] HEX_DIGIT_TOP  = 8'h39;
    localparam logic [BYTE_W-1:0] HEX_LETTER_ADJ = 8'h37;
    localparam logic [BYTE_W-1:0] HALF_DAY       = 8'd12;
    localparam logic [NIB_W-1:0]  BLANK_DIGIT    = 4'd10;
    localparam logic [NIB_W-1:0]  TZ_RESET       = 4'd4;

    localparam logic [COUNT_W-1:0] TIME_KEEP  = 5'd4;
    localparam logic [COUNT_W-1:0] TIME_MAX   = 5'd16;
    localparam logic [COUNT_W-1:0] TIME_SHORT = 5'd7;

    typedef logic [NIB_W-1:0] nib_t;

    // Expected character for each header phase; the comma ends the header.
    function automatic logic [BYTE_W-1:0] header_char(input logic [PHASE_W-1:0] phase);
        logic [BYTE_W-1:0] ch;
        case (phase)
            PH_HDR_G: ch = CH_G;
            PH_HDR_P: ch = CH_P;
            PH_HDR_R: ch = CH_R;
            PH_HDR_M: ch = CH_M;
            PH_HDR_C: ch = CH_C;
            PH_COMMA: ch = CH_COMMA;
            default:  ch = CH_DOLLAR;
        endcase
        return ch;
    endfunction

    function automatic nib_t hex_nibble(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] v;
        v = (b > HEX_DIGIT_TOP) ? b - HEX_LETTER_ADJ : b;
        return v[NIB_W-1:0];
    endfunction

    // Turns the UTC hour digits into 12-hour form shifted back by the offset.
    // The subtraction wraps at eight bits, as for offsets above twelve.
    function automatic logic [2*NIB_W-1:0] convert_hour(input nib_t d0, input nib_t d1,
                                                        input nib_t tz);
        logic [BYTE_W-1:0] h;
        logic [BYTE_W-1:0] tz8;
        nib_t              t0;
        nib_t              t1;
        tz8 = {{(BYTE_W-NIB_W){1'b0}}, tz};
        h = ({{(BYTE_W-NIB_W){1'b0}}, d0} << 3) + ({{(BYTE_W-NIB_W){1'b0}}, d0} << 1)
            + {{(BYTE_W-NIB_W){1'b0}}, d1};
        if (h > HALF_DAY) begin
            h = h - HALF_DAY;
        end
        if (h <= tz8) begin
            h = h + HALF_DAY;
        end
        h = h - tz8;
        if (h > 8'd9) begin
            t0 = 4'd1;
            h  = h - 8'd10;
        end else begin
            t0 = 4'd0;
        end
        t1 = h[NIB_W-1:0];
        return {t0, t1};
    endfunction

endpackage

`default_nettype wire

FILE: design/nmea_rmc_time_extractor_core.sv
// NMEA RMC time extractor: parses "$GPRMC," sentences byte by byte and
// emits four display digits of the time when the checksum matches.
// Depends on nrte_pkg.
//
//   channel  direction  payload                                    handshake
//   s_       in         s_rx_byte[7:0]                             s_valid/s_ready
//   m_       out        m_hour_tens/ones, m_minute_tens/ones [3:0] m_valid/m_ready
//   cfg_     in         cfg_wdata[3:0] (timezone offset)           cfg_wen
//
// One byte per cycle is sustained. A byte enters an input register and is
// then parsed, which updates the parser state and on a checksum match loads
// the result register. The input stage only stalls when the byte that ends a
// matching sentence finds the result register holding an item not yet taken.
// Reset (aresetn low, synchronous) clears the parser, the digit store and both
// valid flags and sets the offset to 4.
`default_nettype none

module nmea_rmc_time_extractor_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wen,
    input  wire logic [3:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [3:0]      m_hour_tens,
    output logic [3:0]      m_hour_ones,
    output logic [3:0]      m_minute_tens,
    output logic [3:0]      m_minute_ones
);

    logic                            in_valid_reg;
    logic [nrte_pkg::BYTE_W-1:0]     in_byte_reg;
    logic                            advance;

    nrte_pkg::nib_t                  tz_reg;
    logic [nrte_pkg::PHASE_W-1:0]    phase_reg, phase_next;
    logic [nrte_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [nrte_pkg::BYTE_W-1:0]     xor_reg, xor_next;
    logic [nrte_pkg::BYTE_W-1:0]     saved_reg, saved_next;
    nrte_pkg::nib_t                  sum_high_reg, sum_high_next;
    nrte_pkg::nib_t                  digit_reg [4];
    nrte_pkg::nib_t                  digit_next [4];

    logic                            emit;
    logic [2*nrte_pkg::NIB_W-1:0]    hour_conv;
    logic [nrte_pkg::BYTE_W-1:0]     got_sum;

    logic                            m_valid_reg;
    nrte_pkg::nib_t                  out_reg [4];

    assign advance = in_valid_reg && (!emit || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign hour_conv = nrte_pkg::convert_hour(digit_reg[0], digit_reg[1], tz_reg);
    assign got_sum   = {sum_high_reg, nrte_pkg::hex_nibble(in_byte_reg)};

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        xor_next      = (in_byte_reg != nrte_pkg::CH_STAR) ? xor_reg ^ in_byte_reg : xor_reg;
        saved_next    = saved_reg;
        sum_high_next = sum_high_reg;
        digit_next    = digit_reg;
        emit          = 1'b0;
        case (phase_reg)
            nrte_pkg::PH_IDLE: begin
                phase_next = (in_byte_reg == nrte_pkg::CH_DOLLAR) ? nrte_pkg::PH_HDR_G
                                                                  : nrte_pkg::PH_IDLE;
                xor_next   = '0;
            end
            nrte_pkg::PH_HDR_G, nrte_pkg::PH_HDR_P, nrte_pkg::PH_HDR_R,
            nrte_pkg::PH_HDR_M, nrte_pkg::PH_HDR_C, nrte_pkg::PH_COMMA: begin
                if (phase_reg == nrte_pkg::PH_COMMA) begin
                    count_next = '0;
                end
                if (in_byte_reg == nrte_pkg::header_char(phase_reg)) begin
                    phase_next = phase_reg + 4'd1;
                end else begin
                    phase_next = nrte_pkg::PH_IDLE;
                end
            end
            nrte_pkg::PH_TIME: begin
                if (in_byte_reg == nrte_pkg::CH_COMMA) begin
                    if (count_reg > nrte_pkg::TIME_SHORT) begin
                        digit_next[0] = hour_conv[2*nrte_pkg::NIB_W-1:nrte_pkg::NIB_W];
                        digit_next[1] = hour_conv[nrte_pkg::NIB_W-1:0];
                    end
                    count_next = '0;
                    phase_next = nrte_pkg::PH_STAR;
                end else if (count_reg < nrte_pkg::TIME_MAX) begin
                    if (count_reg < nrte_pkg::TIME_KEEP) begin
                        digit_next[count_reg[1:0]] = in_byte_reg[nrte_pkg::NIB_W-1:0];
                    end
                    count_next = count_reg + 5'd1;
                end
            end
            nrte_pkg::PH_STAR: begin
                if (in_byte_reg == nrte_pkg::CH_STAR) begin
                    saved_next = xor_next;
                    phase_next = nrte_pkg::PH_SUM_H;
                end
            end
            nrte_pkg::PH_SUM_H: begin
                sum_high_next = nrte_pkg::hex_nibble(in_byte_reg);
                phase_next    = nrte_pkg::PH_SUM_L;
            end
            nrte_pkg::PH_SUM_L: begin
                emit = (got_sum == saved_reg);
                for (int i = 0; i < 4; i++) begin
                    digit_next[i] = '0;
                end
                phase_next = nrte_pkg::PH_IDLE;
            end
            default: begin
                phase_next = nrte_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tz_reg <= nrte_pkg::TZ_RESET;
        end else if (cfg_wen) begin
            tz_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= nrte_pkg::PH_IDLE;
            count_reg    <= '0;
            xor_reg      <= '0;
            saved_reg    <= '0;
            sum_high_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                digit_reg[i] <= '0;
            end
        end else if (advance) begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            xor_reg      <= xor_next;
            saved_reg    <= saved_next;
            sum_high_reg <= sum_high_next;
            digit_reg    <= digit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_reg[0] <= (digit_reg[0] == '0) ? nrte_pkg::BLANK_DIGIT : digit_reg[0];
            out_reg[1] <= digit_reg[1];
            out_reg[2] <= digit_reg[2];
            out_reg[3] <= digit_reg[3];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hour_tens   = out_reg[0];
    assign m_hour_ones   = out_reg[1];
    assign m_minute_tens = out_reg[2];
    assign m_minute_ones = out_reg[3];

endmodule

`default_nettype wire

FILE: verif/nmea_rmc_time_extractor_core_tb.sv
// Self-checking testbench for nmea_rmc_time_extractor_core: feeds NMEA byte streams
// under random valid/ready idling and checks every display-digit item against a local
// predictor. Depends on nrte_pkg and the core.
`default_nettype none

module nmea_rmc_time_extractor_core_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 150;
    localparam int TZ_PHASES     = 6;
    localparam int MAX_WAIT      = 18;

    typedef logic [nrte_pkg::BYTE_W-1:0] byte_q_t[$];

    typedef struct packed {
        nrte_pkg::nib_t hour_tens;
        nrte_pkg::nib_t hour_ones;
        nrte_pkg::nib_t minute_tens;
        nrte_pkg::nib_t minute_ones;
    } disp_digits_t;

    typedef enum int {SUM_UPPER, SUM_LOWER, SUM_BAD, SUM_JUNK} sum_style_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [3:0]  cfg_wdata = 4'd0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'd0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [3:0]  m_hour_tens;
    logic [3:0]  m_hour_ones;
    logic [3:0]  m_minute_tens;
    logic [3:0]  m_minute_ones;

    // Predictor state.
    logic [nrte_pkg::PHASE_W-1:0] scan_phase;
    logic [nrte_pkg::COUNT_W-1:0] time_len;
    logic [nrte_pkg::BYTE_W-1:0]  line_xor;
    logic [nrte_pkg::BYTE_W-1:0]  star_xor;
    nrte_pkg::nib_t               sum_high;
    nrte_pkg::nib_t               clock_nib [4];
    nrte_pkg::nib_t               offset_now = nrte_pkg::TZ_RESET;

    disp_digits_t digits_due[$];
    byte_q_t      bytes_due;

    int failures     = 0;
    int cycle_count  = 0;
    int queued_count = 0;
    int src_wait     = 0;
    int src_stretch  = 0;
    int sink_wait    = 0;
    int sink_stretch = 0;
    bit src_calm     = 1'b0;
    bit sink_calm    = 1'b0;

    nmea_rmc_time_extractor_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hour_tens   (m_hour_tens),
        .m_hour_ones   (m_hour_ones),
        .m_minute_tens (m_minute_tens),
        .m_minute_ones (m_minute_ones)
    );

    always #4 aclk = ~aclk;

    // Gaps come in stretches: some stretches have no idling at all.
    function automatic int pick_gap(inout int left, inout bit calm);
        if (left == 0) begin
            left = $urandom_range(10, 80);
            calm = ($urandom_range(0, 3) == 0);
        end
        left--;
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic nrte_pkg::nib_t hex_value(input logic [nrte_pkg::BYTE_W-1:0] b);
        logic [nrte_pkg::BYTE_W-1:0] adj;
        adj = b;
        if (b > nrte_pkg::HEX_DIGIT_TOP) begin
            adj = b - nrte_pkg::HEX_LETTER_ADJ;
        end
        return adj[3:0];
    endfunction

    function automatic logic [nrte_pkg::BYTE_W-1:0] hex_char(input nrte_pkg::nib_t n,
                                                             input logic lower);
        if (n < 4'd10) begin
            return 8'h30 + 8'(n);
        end
        return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic byte_q_t text_bytes(input string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++) begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    // Works out what one accepted byte does to the parser and any item it produces.
    task automatic parse_byte(input logic [nrte_pkg::BYTE_W-1:0] b);
        logic [nrte_pkg::BYTE_W-1:0] want_ch;
        logic [nrte_pkg::BYTE_W-1:0] heard;
        int                          h;
        disp_digits_t                d;
        if (b != nrte_pkg::CH_STAR) begin
            line_xor = line_xor ^ b;
        end
        if (scan_phase == nrte_pkg::PH_IDLE) begin
            scan_phase = (b == nrte_pkg::CH_DOLLAR) ? nrte_pkg::PH_HDR_G : nrte_pkg::PH_IDLE;
            line_xor   = '0;
        end else if (scan_phase <= nrte_pkg::PH_COMMA) begin
            case (scan_phase)
                nrte_pkg::PH_HDR_G: want_ch = nrte_pkg::CH_G;
                nrte_pkg::PH_HDR_P: want_ch = nrte_pkg::CH_P;
                nrte_pkg::PH_HDR_R: want_ch = nrte_pkg::CH_R;
                nrte_pkg::PH_HDR_M: want_ch = nrte_pkg::CH_M;
                nrte_pkg::PH_HDR_C: want_ch = nrte_pkg::CH_C;
                default:            want_ch = nrte_pkg::CH_COMMA;
            endcase
            if (scan_phase == nrte_pkg::PH_COMMA) begin
                time_len = '0;
            end
            scan_phase = (b == want_ch) ? scan_phase + 1'b1 : nrte_pkg::PH_IDLE;
        end else if (scan_phase == nrte_pkg::PH_TIME) begin
            if (b == nrte_pkg::CH_COMMA) begin
                if (time_len > nrte_pkg::TIME_SHORT) begin
                    h = clock_nib[0] * 10 + clock_nib[1];
                    if (h > nrte_pkg::HALF_DAY) begin
                        h = h - nrte_pkg::HALF_DAY;
                    end
                    if (h <= offset_now) begin
                        h = h + nrte_pkg::HALF_DAY;
                    end
                    h = (h - offset_now) & 8'hFF;
                    if (h > 9) begin
                        clock_nib[0] = 4'd1;
                        h = h - 10;
                    end else begin
                        clock_nib[0] = 4'd0;
                    end
                    clock_nib[1] = h[3:0];
                end
                time_len   = '0;
                scan_phase = nrte_pkg::PH_STAR;
            end else if (time_len < nrte_pkg::TIME_MAX) begin
                if (time_len < nrte_pkg::TIME_KEEP) begin
                    clock_nib[time_len[1:0]] = b[3:0];
                end
                time_len = time_len + 1'b1;
            end
        end else if (scan_phase == nrte_pkg::PH_STAR) begin
            if (b == nrte_pkg::CH_STAR) begin
                star_xor   = line_xor;
                scan_phase = nrte_pkg::PH_SUM_H;
            end
        end else if (scan_phase == nrte_pkg::PH_SUM_H) begin
            sum_high   = hex_value(b);
            scan_phase = nrte_pkg::PH_SUM_L;
        end else if (scan_phase == nrte_pkg::PH_SUM_L) begin
            heard = {sum_high, hex_value(b)};
            if (heard == star_xor) begin
                d.hour_tens   = (clock_nib[0] == 4'd0) ? nrte_pkg::BLANK_DIGIT : clock_nib[0];
                d.hour_ones   = clock_nib[1];
                d.minute_tens = clock_nib[2];
                d.minute_ones = clock_nib[3];
                digits_due.push_back(d);
            end
            foreach (clock_nib[i]) begin
                clock_nib[i] = '0;
            end
            scan_phase = nrte_pkg::PH_IDLE;
        end else begin
            scan_phase = nrte_pkg::PH_IDLE;
        end
    endtask

    task automatic stage(input byte_q_t q);
        foreach (q[i]) begin
            bytes_due.push_back(q[i]);
        end
        queued_count += q.size();
    endtask

    task automatic queue_sentence(input byte_q_t tfield, input byte_q_t body,
                                  input sum_style_t style);
        byte_q_t                     line;
        logic [nrte_pkg::BYTE_W-1:0] sum;
        logic                        lower;
        line = '{nrte_pkg::CH_DOLLAR, nrte_pkg::CH_G, nrte_pkg::CH_P, nrte_pkg::CH_R,
                 nrte_pkg::CH_M, nrte_pkg::CH_C, nrte_pkg::CH_COMMA};
        foreach (tfield[i]) begin
            line.push_back(tfield[i]);
        end
        line.push_back(nrte_pkg::CH_COMMA);
        foreach (body[i]) begin
            line.push_back(body[i]);
        end
        sum = '0;
        for (int i = 1; i < line.size(); i++) begin
            if (line[i] != nrte_pkg::CH_STAR) begin
                sum = sum ^ line[i];
            end
        end
        line.push_back(nrte_pkg::CH_STAR);
        lower = (style == SUM_LOWER);
        if (style == SUM_BAD) begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        if (style == SUM_JUNK) begin
            line.push_back(8'($urandom_range(0, 255)));
            line.push_back(8'($urandom_range(0, 255)));
        end else begin
            line.push_back(hex_char(sum[7:4], lower));
            line.push_back(hex_char(sum[3:0], lower));
        end
        stage(line);
    endtask

    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (bytes_due.size() != 0 || s_valid || digits_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic void check_digit(input string field, input nrte_pkg::nib_t want,
                                        input nrte_pkg::nib_t got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endfunction

    // Driver: one byte item at a time, prediction at acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            scan_phase = nrte_pkg::PH_IDLE;
            time_len   = '0;
            line_xor   = '0;
            star_xor   = '0;
            sum_high   = '0;
            foreach (clock_nib[i]) begin
                clock_nib[i] = '0;
            end
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_rx_byte);
            end
            if (!s_valid || s_ready) begin
                if (src_wait != 0) begin
                    src_wait--;
                    s_valid <= 1'b0;
                end else if (bytes_due.size() != 0) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= bytes_due.pop_front();
                    src_wait  = pick_gap(src_stretch, src_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls count down only while an item is offered.
    always @(posedge aclk) begin
        disp_digits_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (digits_due.size() == 0) begin
                    $error("item with none expected: %0d %0d %0d %0d", m_hour_tens,
                           m_hour_ones, m_minute_tens, m_minute_ones);
                    failures++;
                end else begin
                    want = digits_due.pop_front();
                    check_digit("hour_tens", want.hour_tens, m_hour_tens);
                    check_digit("hour_ones", want.hour_ones, m_hour_ones);
                    check_digit("minute_tens", want.minute_tens, m_minute_tens);
                    check_digit("minute_ones", want.minute_ones, m_minute_ones);
                end
                sink_wait = pick_gap(sink_stretch, sink_calm);
            end else if (m_valid && sink_wait != 0) begin
                sink_wait--;
            end
            m_ready <= (sink_wait == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        sum_style_t                  style;
        byte_q_t                     tfield;
        byte_q_t                     body;
        byte_q_t                     junk;
        logic [nrte_pkg::BYTE_W-1:0] b;
        int                          kind;
        int                          hour;
        int                          minute;
        int                          len;
        int                          target;
        nrte_pkg::nib_t              tz_next;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        queue_sentence(text_bytes("123456.00"), text_bytes("A,"), SUM_UPPER);
        queue_sentence(text_bytes("000059.99"), text_bytes(""), SUM_LOWER);
        queue_sentence(text_bytes(""), text_bytes(""), SUM_UPPER);
        queue_sentence(text_bytes("1234567"), text_bytes(""), SUM_LOWER);
        queue_sentence(text_bytes("19000000"), text_bytes(""), SUM_UPPER);
        queue_sentence(text_bytes("23$4*5.000000000000000"), text_bytes("$"), SUM_UPPER);
        queue_sentence(text_bytes("0000000"), text_bytes("V"), SUM_BAD);
        stage(text_bytes("$GP"));
        queue_sentence(text_bytes("091500.00"), text_bytes(""), SUM_UPPER);
        queue_sentence(text_bytes("120000.00"), text_bytes(""), SUM_JUNK);
        stage('{8'h00, 8'hFF});
        wait_drained();

        for (int p = 0; p < TZ_PHASES; p++) begin
            case (p)
                0:       tz_next = 4'd0;
                1:       tz_next = 4'd12;
                2:       tz_next = 4'd15;
                3:       tz_next = 4'd9;
                default: tz_next = 4'($urandom_range(0, 15));
            endcase
            cfg_wen    <= 1'b1;
            cfg_wdata  <= tz_next;
            offset_now = tz_next;
            @(posedge aclk);
            cfg_wen <= 1'b0;
            @(negedge aclk);

            target = queued_count + PHASE_BYTES;
            while (queued_count < target) begin
                kind = $urandom_range(0, 19);
                if (kind < 14) begin
                    tfield.delete();
                    body.delete();
                    kind = $urandom_range(0, 9);
                    if (kind < 8) begin
                        hour   = (kind == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
                        minute = $urandom_range(0, 59);
                        tfield.push_back(8'h30 + 8'(hour / 10));
                        tfield.push_back(8'h30 + 8'(hour % 10));
                        tfield.push_back(8'h30 + 8'(minute / 10));
                        tfield.push_back(8'h30 + 8'(minute % 10));
                        tfield.push_back(8'h30 + 8'($urandom_range(0, 5)));
                        tfield.push_back(8'h30 + 8'($urandom_range(0, 9)));
                        tfield.push_back(8'h2E);
                        tfield.push_back(8'h30 + 8'($urandom_range(0, 9)));
                        tfield.push_back(8'h30 + 8'($urandom_range(0, 9)));
                        len = (kind == 1) ? 6 : (kind == 2) ? 7 : (kind == 3) ? 8 : 9;
                        while (tfield.size() > len) begin
                            tfield.pop_back();
                        end
                    end else begin
                        repeat ($urandom_range(0, 20)) begin
                            do begin
                                b = 8'($urandom_range(0, 255));
                            end while (b == nrte_pkg::CH_COMMA);
                            tfield.push_back(b);
                        end
                    end
                    repeat ($urandom_range(0, 12)) begin
                        do begin
                            b = 8'($urandom_range(0, 255));
                        end while (b == nrte_pkg::CH_STAR);
                        body.push_back(b);
                    end
                    kind = $urandom_range(0, 9);
                    if (kind == 0) begin
                        style = SUM_BAD;
                    end else if (kind == 1) begin
                        style = SUM_JUNK;
                    end else if (kind < 6) begin
                        style = SUM_UPPER;
                    end else begin
                        style = SUM_LOWER;
                    end
                    queue_sentence(tfield, body, style);
                end else if (kind < 17) begin
                    junk.delete();
                    repeat ($urandom_range(1, 6)) begin
                        junk.push_back(8'($urandom_range(0, 255)));
                    end
                    stage(junk);
                end else begin
                    junk = '{nrte_pkg::CH_DOLLAR, nrte_pkg::CH_G, nrte_pkg::CH_P,
                             nrte_pkg::CH_R, nrte_pkg::CH_M, nrte_pkg::CH_C};
                    len = $urandom_range(1, 6);
                    while (junk.size() > len) begin
                        junk.pop_back();
                    end
                    junk.push_back(8'($urandom_range(0, 255)));
                    stage(junk);
                end
            end
            wait_drained();
        end

        if (failures == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: nmea_rmc_time_extractor_core.f
design/nrte_pkg.sv
design/nmea_rmc_time_extractor_core.sv
verif/nmea_rmc_time_extractor_core_tb.sv
